>>> hdl/modified_utf8_decoder_top_macros.svh
// ----------------------------------------------------------------------------
// Modified UTF-8 decoder assertion macros
// Shared assertion forms for the decoder's checker.
// ----------------------------------------------------------------------------
`ifndef MODIFIED_UTF8_DECODER_TOP_MACROS_SVH
`define MODIFIED_UTF8_DECODER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MU8D_ASSERT_SAME(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("assertion failed: lbl");

// The consequent must hold in the cycle after the antecedent.
`define MU8D_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("assertion failed: lbl");

`endif

>>> hdl/mu8d_pkg.sv
// ----------------------------------------------------------------------------
// Modified UTF-8 decoder package
// Types, constants and the byte classifier shared by the decoder's files.
// ----------------------------------------------------------------------------
`default_nettype none

package mu8d_pkg;

    // Width of a decoded code point.
    localparam int CpW = 21;

    // Depth of the queue between the front and the back.
    localparam int QDepth = 4;
    localparam int QAw    = $clog2(QDepth);

    // The decode window holds up to five waiting bytes plus the new one.
    localparam int WinMax = 6;
    localparam int WinCw  = $clog2(WinMax + 1);

    // Pattern of a surrogate pair: ED A0-AF 80-BF ED B0-BF 80-BF.
    localparam logic [7:0] SupMask [WinMax] = '{8'hFF, 8'hF0, 8'hC0, 8'hFF, 8'hF0, 8'hC0};
    localparam logic [7:0] SupVal  [WinMax] = '{8'hED, 8'hA0, 8'h80, 8'hED, 8'hB0, 8'h80};

    // Role of a byte, judged from its upper nibble.
    typedef enum logic [2:0] {
        BC_ASCII,
        BC_CONT,
        BC_LEAD2,
        BC_LEAD3,
        BC_BAD
    } t_byte_class;

    // One classified item as it waits in the queue.
    typedef struct packed {
        logic [7:0]  data;
        logic        eos;
        t_byte_class cls;
    } t_qitem;

    // One slot of the decode window.
    typedef struct packed {
        logic [7:0]  data;
        t_byte_class cls;
    } t_witem;

    // Back-end sequencer states.
    typedef enum logic {
        BK_LOAD,
        BK_DECIDE
    } t_back_state;

    // Outcome of one decision at the head of the window.
    typedef struct packed {
        logic           wait_more;
        logic [2:0]     used;
        logic [CpW-1:0] cp;
        logic           bad;
    } t_decision;

    // Sort a raw byte by its upper nibble.
    function automatic t_byte_class classify(input logic [7:0] b);
        t_byte_class c;
        case (b[7:4]) inside
            [4'h0:4'h7]: c = BC_ASCII;
            [4'h8:4'hB]: c = BC_CONT;
            4'hC, 4'hD:  c = BC_LEAD2;
            4'hE:        c = BC_LEAD3;
            default:     c = BC_BAD;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> hdl/mu8d_if.sv
// ----------------------------------------------------------------------------
// Modified UTF-8 decoder channels
// Valid/ready channels for input bytes, queued items and decoded results.
// ----------------------------------------------------------------------------
`default_nettype none

// Input channel: one raw byte per item.
interface mu8d_in_if import mu8d_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_string;

    modport source (output valid, in_byte, end_of_string, input ready);
    modport sink   (input valid, in_byte, end_of_string, output ready);
endinterface

// Internal channel: classified items from the front queue to the back.
interface mu8d_q_if import mu8d_pkg::*; ();
    logic   valid;
    logic   ready;
    t_qitem item;

    modport source (output valid, item, input ready);
    modport sink   (input valid, item, output ready);
endinterface

// Output channel: one decoded character per item.
interface mu8d_out_if import mu8d_pkg::*; ();
    logic           valid;
    logic           ready;
    logic [CpW-1:0] code_point;
    logic           malformed;
    logic           last_of_string;

    modport source (output valid, code_point, malformed, last_of_string, input ready);
    modport sink   (input valid, code_point, malformed, last_of_string, output ready);
endinterface

`default_nettype wire

>>> hdl/mu8d_front.sv
// ----------------------------------------------------------------------------
// Modified UTF-8 decoder front end
// Accepts input bytes, classifies them and holds them in a small queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mu8d_front import mu8d_pkg::*; (
    input  wire           i_clk,
    input  wire           i_rst_n,
    mu8d_in_if.sink       i_in,
    mu8d_q_if.source      o_q
);

    t_qitem             r_mem [QDepth];
    logic [QAw-1:0]     r_wr_ptr;
    logic [QAw-1:0]     r_rd_ptr;
    logic [QAw:0]       r_cnt;
    logic [QAw-1:0]     n_wr_ptr;
    logic [QAw-1:0]     n_rd_ptr;
    logic [QAw:0]       n_cnt;
    logic               push;
    logic               pop;
    t_qitem             new_item;

    // Handshakes on both sides of the queue.
    assign i_in.ready = (r_cnt != (QAw + 1)'(QDepth));
    assign push       = i_in.valid && i_in.ready;
    assign o_q.valid  = (r_cnt != '0);
    assign o_q.item   = r_mem[r_rd_ptr];
    assign pop        = o_q.valid && o_q.ready;

    // Classify the byte as it enters.
    always_comb begin
        new_item.data = i_in.in_byte;
        new_item.eos  = i_in.end_of_string;
        new_item.cls  = classify(i_in.in_byte);
    end

    // Pointer and fill-count updates.
    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_cnt    = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    // Queue control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= new_item;
        end
    end

endmodule

`default_nettype wire

>>> hdl/mu8d_back.sv
// ----------------------------------------------------------------------------
// Modified UTF-8 decoder back end
// Loads queued bytes into the decode window and emits results from it.
// ----------------------------------------------------------------------------
`default_nettype none

module mu8d_back import mu8d_pkg::*; (
    input  wire           i_clk,
    input  wire           i_rst_n,
    mu8d_q_if.sink        i_q,
    mu8d_out_if.source    o_out
);

    t_witem [WinMax-1:0] r_win;
    t_witem [WinMax-1:0] n_win;
    logic [WinCw-1:0]    r_n;
    logic [WinCw-1:0]    n_n;
    logic                r_fin;
    logic                n_fin;
    t_back_state         r_state;
    t_back_state         n_state;
    logic                r_out_valid;
    logic                n_out_valid;
    logic [CpW-1:0]      r_out_cp;
    logic                r_out_bad;
    logic                r_out_last;

    t_witem [WinMax-1:0] wb;
    logic [WinMax-1:0]   have;
    t_decision           dec;
    logic                sup_stop;
    logic                sup_wait;
    logic                load;
    logic                emit;
    logic                slot_free;
    logic [WinCw-1:0]    left;

    // Window view in which slots past the fill read as a zero byte.
    always_comb begin
        for (int k = 0; k < WinMax; k++) begin
            have[k] = (WinCw'(k) < r_n);
            wb[k]   = have[k] ? r_win[k] : t_witem'{data: 8'h00, cls: BC_ASCII};
        end
    end

    // Decide the sequence at the head of the window.
    always_comb begin
        sup_stop = 1'b0;
        sup_wait = 1'b0;
        dec      = '0;
        for (int k = 0; k < WinMax; k++) begin
            if (!sup_stop) begin
                if (!have[k] && !r_fin) begin
                    sup_wait = 1'b1;
                    sup_stop = 1'b1;
                end else if ((wb[k].data & SupMask[k]) != SupVal[k]) begin
                    sup_stop = 1'b1;
                end
            end
        end
        if (sup_wait) begin
            dec.wait_more = 1'b1;
        end else if (!sup_stop) begin
            // Surrogate pair: 0x10000 plus the twenty payload bits.
            dec.cp   = {({1'b0, wb[1].data[3:0]} + 5'd1), wb[2].data[5:0],
                        wb[4].data[3:0], wb[5].data[5:0]};
            dec.used = 3'd6;
        end else begin
            dec.cp   = {13'b0, wb[0].data};
            dec.used = 3'd1;
            case (wb[0].cls)
                BC_ASCII: begin
                    dec.bad = 1'b0;
                end
                BC_LEAD2: begin
                    if (!have[1] && !r_fin) begin
                        dec.wait_more = 1'b1;
                    end else if (wb[1].cls == BC_CONT) begin
                        dec.cp   = {10'b0, wb[0].data[4:0], wb[1].data[5:0]};
                        dec.used = 3'd2;
                    end else begin
                        dec.bad = 1'b1;
                    end
                end
                BC_LEAD3: begin
                    if (!have[1] && !r_fin) begin
                        dec.wait_more = 1'b1;
                    end else if (wb[1].cls == BC_CONT) begin
                        if (!have[2] && !r_fin) begin
                            dec.wait_more = 1'b1;
                        end else if (wb[2].cls == BC_CONT) begin
                            dec.cp   = {5'b0, wb[0].data[3:0], wb[1].data[5:0],
                                        wb[2].data[5:0]};
                            dec.used = 3'd3;
                        end else begin
                            dec.bad = 1'b1;
                        end
                    end else begin
                        dec.bad = 1'b1;
                    end
                end
                default: begin
                    dec.bad = 1'b1;
                end
            endcase
        end
    end

    assign slot_free = !r_out_valid || o_out.ready;
    assign left      = r_n - WinCw'(dec.used);

    // Sequencer outputs.
    always_comb begin
        i_q.ready = 1'b0;
        load      = 1'b0;
        emit      = 1'b0;
        case (r_state)
            BK_LOAD: begin
                i_q.ready = 1'b1;
                load      = i_q.valid;
            end
            BK_DECIDE: begin
                emit = !dec.wait_more && slot_free;
            end
            default: begin
                i_q.ready = 1'b0;
            end
        endcase
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_LOAD: begin
                if (i_q.valid) begin
                    n_state = BK_DECIDE;
                end
            end
            BK_DECIDE: begin
                if (dec.wait_more) begin
                    n_state = BK_LOAD;
                end else if (emit && (left == '0)) begin
                    n_state = BK_LOAD;
                end
            end
            default: begin
                n_state = BK_LOAD;
            end
        endcase
    end

    // Window contents, fill and end-of-string flag.
    always_comb begin
        n_win = r_win;
        n_n   = r_n;
        n_fin = r_fin;
        if (load) begin
            n_win[r_n[2:0]] = '{data: i_q.item.data, cls: i_q.item.cls};
            n_n             = r_n + 1'b1;
            n_fin           = i_q.item.eos;
        end else if (emit) begin
            n_n = left;
            case (dec.used)
                3'd1:    n_win = r_win >> $bits(t_witem);
                3'd2:    n_win = r_win >> (2 * $bits(t_witem));
                3'd3:    n_win = r_win >> (3 * $bits(t_witem));
                default: n_win = r_win;
            endcase
        end
    end

    // Output register valid.
    always_comb begin
        n_out_valid = r_out_valid;
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_LOAD;
            r_n         <= '0;
            r_fin       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_n         <= n_n;
            r_fin       <= n_fin;
            r_out_valid <= n_out_valid;
        end
    end

    // Window and result payload.
    always_ff @(posedge i_clk) begin
        r_win <= n_win;
        if (emit) begin
            r_out_cp   <= dec.cp;
            r_out_bad  <= dec.bad;
            r_out_last <= r_fin && (left == '0);
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.code_point     = r_out_cp;
    assign o_out.malformed      = r_out_bad;
    assign o_out.last_of_string = r_out_last;

endmodule

`default_nettype wire

>>> hdl/modified_utf8_decoder_top.sv
// A streaming decoder for modified UTF-8: each input item is one byte, and
// each result item is one character with a malformed flag and a flag on the
// last result of a string. A front end classifies bytes into a four-entry
// queue; the back end moves a byte into its six-byte decode window in its
// load state and then, in its decision state, either emits a result or finds
// that the head of the window still needs bytes and goes back to loading.
// Each further result from the same byte, as in a fallback burst or an
// end-of-string flush, needs a decision of its own before the next byte is
// loaded. A stalled output holds the back end while the queue keeps taking
// bytes until it is full.
// ----------------------------------------------------------------------------
// Modified UTF-8 decoder top level
// Connects the classifying front end, its queue and the decoding back end.
// ----------------------------------------------------------------------------
`default_nettype none

module modified_utf8_decoder_top import mu8d_pkg::*; (
    input  wire           i_clk,
    input  wire           i_rst_n,
    mu8d_in_if.sink       i_in,
    mu8d_out_if.source    o_out
);

    // Channel between the front queue and the back end.
    mu8d_q_if u_q ();

    // Front end: accept and classify bytes.
    mu8d_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_q     (u_q)
    );

    // Back end: decode the window and deliver results.
    mu8d_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q     (u_q),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

>>> hdl/mu8d_checker.sv
// ----------------------------------------------------------------------------
// Modified UTF-8 decoder checker
// Watches the decoder's output channel and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "modified_utf8_decoder_top_macros.svh"

module mu8d_checker import mu8d_pkg::*; (
    input wire           i_clk,
    input wire           i_rst_n,
    input wire           i_out_valid,
    input wire           i_out_ready,
    input wire [CpW-1:0] i_out_code_point,
    input wire           i_out_malformed,
    input wire           i_out_last
);

    logic high_byte;

    // A malformed item carries one byte value from 0x80 to 0xFF.
    assign high_byte = (i_out_code_point[CpW-1:8] == '0) && i_out_code_point[7];

    // Reset empties the output register.
    `MU8D_ASSERT_NEXT(a_reset_clears_out, i_clk, 1'b0, !i_rst_n, !i_out_valid)

    // A malformed item never carries an ASCII byte or a wide code point.
    `MU8D_ASSERT_SAME(a_bad_is_high_byte, i_clk, !i_rst_n, i_out_valid && i_out_malformed, high_byte)

    // A stalled item stays offered.
    `MU8D_ASSERT_NEXT(a_valid_holds, i_clk, !i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // A stalled item keeps its payload.
    `MU8D_ASSERT_NEXT(a_payload_holds, i_clk, !i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_code_point) && $stable(i_out_malformed) && $stable(i_out_last))

endmodule

bind modified_utf8_decoder_top mu8d_checker u_mu8d_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_code_point (o_out.code_point),
    .i_out_malformed  (o_out.malformed),
    .i_out_last       (o_out.last_of_string)
);

`default_nettype wire

>>> sim/modified_utf8_decoder_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modified UTF-8 decoder testbench
// Streams byte strings into the decoder and compares every decoded character
// with a predictor kept inside the bench. The strings are a directed set of
// edge cases, then random strings under several idle patterns, then a long
// output hold that fills the decoder and stalls its input.
// ----------------------------------------------------------------------------

module modified_utf8_decoder_top_tb;
    import mu8d_pkg::*;

    // One decoded character as the output channel carries it.
    typedef struct packed {
        logic [CpW-1:0] cp;
        logic           bad;
        logic           last;
    } decoded_char_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mu8d_in_if  in_ch ();
    mu8d_out_if out_ch ();

    modified_utf8_decoder_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state: bytes still waiting for a decision.
    logic [7:0]    win_buf [0:5];
    int unsigned   win_len = 0;
    decoded_char_t chars_due [$];

    // Idle pattern and output hold requests.
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;
    int unsigned hold_req_len = 0;
    int unsigned hold_req_id  = 0;

    // Run statistics.
    int unsigned fault_cnt     = 0;
    int unsigned bytes_sent    = 0;
    int unsigned chars_checked = 0;
    int unsigned bad_seen      = 0;
    int unsigned supp_seen     = 0;
    int unsigned strings_sent  = 0;

    function automatic void log_fault(input string msg);
        fault_cnt++;
        if (fault_cnt <= 10) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
    endfunction

    // Window byte at position k; bytes past the end read as zero.
    function automatic logic [7:0] win_at(input int unsigned k);
        return (k < win_len) ? win_buf[k] : 8'h00;
    endfunction

    // Does byte b fit position k of a surrogate pair?
    function automatic bit pair_byte_ok(input int unsigned k, input logic [7:0] b);
        case (k)
            0, 3:    return b == 8'hED;
            1:       return b[7:4] == 4'hA;
            4:       return b[7:4] == 4'hB;
            default: return b[7:6] == 2'b10;
        endcase
    endfunction

    // Decide the sequence at the head of the window. Returns the bytes used,
    // or zero when the head could still become valid with more bytes.
    function automatic int unsigned decode_head(input bit fin, output logic [CpW-1:0] cp,
                                                output logic bad);
        logic [7:0] b0, b1, b2, b4, b5;
        bit         pair;
        pair = 1'b1;
        cp   = '0;
        bad  = 1'b0;
        for (int unsigned k = 0; k < 6; k++) begin
            if (k >= win_len && !fin) return 0;
            if (!pair_byte_ok(k, win_at(k))) begin
                pair = 1'b0;
                break;
            end
        end
        b0 = win_at(0);
        b1 = win_at(1);
        b2 = win_at(2);
        b4 = win_at(4);
        b5 = win_at(5);
        if (pair) begin
            cp = 21'h10000 + {1'b0, b1[3:0], b2[5:0], b4[3:0], b5[5:0]};
            return 6;
        end
        case (b0[7:4])
            4'hC, 4'hD: begin
                if (win_len < 2 && !fin) return 0;
                if (b1[7:6] == 2'b10) begin
                    cp = CpW'({b0[4:0], b1[5:0]});
                    return 2;
                end
            end
            4'hE: begin
                if (win_len < 2 && !fin) return 0;
                if (b1[7:6] == 2'b10) begin
                    if (win_len < 3 && !fin) return 0;
                    if (b2[7:6] == 2'b10) begin
                        cp = CpW'({b0[3:0], b1[5:0], b2[5:0]});
                        return 3;
                    end
                end
            end
            4'h8, 4'h9, 4'hA, 4'hB, 4'hF: ;
            default: begin
                cp = CpW'(b0);
                return 1;
            end
        endcase
        // Malformed lead or continuation: only the lead byte goes out.
        cp  = CpW'(b0);
        bad = 1'b1;
        return 1;
    endfunction

    // Add one accepted byte to the window and queue the characters it completes.
    function automatic void predict_byte(input logic [7:0] b, input logic eos);
        decoded_char_t fresh [0:5];
        int unsigned   used;
        int unsigned   cnt;
        logic [CpW-1:0] cp;
        logic          bad;
        cnt = 0;
        win_buf[win_len] = b;
        win_len++;
        while (win_len > 0 && cnt < 6) begin
            used = decode_head(eos, cp, bad);
            if (used == 0) break;
            if (used > win_len) used = win_len;
            fresh[cnt].cp   = cp;
            fresh[cnt].bad  = bad;
            fresh[cnt].last = 1'b0;
            cnt++;
            for (int unsigned k = 0; k + used < win_len; k++) begin
                win_buf[k] = win_buf[k + used];
            end
            win_len -= used;
        end
        // End of string flushes the window and tags the final character.
        if (eos) begin
            win_len = 0;
            if (cnt > 0) fresh[cnt - 1].last = 1'b1;
        end
        for (int unsigned i = 0; i < cnt; i++) begin
            chars_due.push_back(fresh[i]);
        end
    endfunction

    // Predict on accepted input items, then check accepted result items.
    always @(posedge i_clk) begin
        decoded_char_t got;
        decoded_char_t want;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                predict_byte(in_ch.in_byte, in_ch.end_of_string);
            end
            if (out_ch.valid && out_ch.ready) begin
                got.cp   = out_ch.code_point;
                got.bad  = out_ch.malformed;
                got.last = out_ch.last_of_string;
                chars_checked++;
                if (got.bad === 1'b1) bad_seen++;
                if (got.cp >= 21'h10000) supp_seen++;
                if (chars_due.size() == 0) begin
                    log_fault($sformatf("unexpected item cp=%h bad=%b last=%b",
                                        got.cp, got.bad, got.last));
                end else begin
                    want = chars_due.pop_front();
                    if (got.cp !== want.cp || got.bad !== want.bad ||
                        got.last !== want.last) begin
                        log_fault($sformatf("expected cp=%h bad=%b last=%b, got cp=%h bad=%b last=%b",
                                            want.cp, want.bad, want.last,
                                            got.cp, got.bad, got.last));
                    end
                end
            end
        end
    end

    // Output side: random stalls, plus long holds on request.
    initial begin : receiver
        int unsigned hold_left;
        int unsigned hold_seen_id;
        hold_left    = 0;
        hold_seen_id = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req_id != hold_seen_id) begin
                hold_seen_id = hold_req_id;
                hold_left    = hold_req_len;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Offer one byte after a random gap and wait until it is accepted.
    // Called right after a rising edge; returns right after the accepting edge.
    task automatic send_byte(input logic [7:0] b, input logic eos);
        if ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < tx_idle_pct) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.in_byte       <= b;
        in_ch.end_of_string <= eos;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        bytes_sent++;
        if (eos) strings_sent++;
    endtask

    // Edge cases: field extremes, each sequence length, surrogate pairs,
    // bad leads, bad continuations and truncation at end of string.
    task automatic run_directed_strings();
        send_byte(8'h00, 1'b0); send_byte(8'h7F, 1'b0);
        send_byte(8'hC0, 1'b0); send_byte(8'h80, 1'b0);
        send_byte(8'hDF, 1'b0); send_byte(8'hBF, 1'b1);
        send_byte(8'hEF, 1'b0); send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
        send_byte(8'hED, 1'b0); send_byte(8'hAF, 1'b0); send_byte(8'hBF, 1'b0);
        send_byte(8'hED, 1'b0); send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b1);
        // A lone surrogate followed by a plain character.
        send_byte(8'hED, 1'b0); send_byte(8'hA0, 1'b0); send_byte(8'h80, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h80, 1'b0); send_byte(8'hFF, 1'b0);
        send_byte(8'hC2, 1'b0); send_byte(8'h41, 1'b1);
        // A three-byte sequence cut short by the end of the string.
        send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b1);
    endtask

    // One random character: mostly well formed, some noise, some broken.
    task automatic send_random_char(input bit end_str);
        logic [7:0]  seq [0:5];
        int unsigned len;
        int unsigned roll;
        int unsigned pick;
        roll = $urandom_range(99);
        pick = (roll >= 90) ? $urandom_range(1, 3) : 0;
        len  = 1;
        if (roll < 25) begin
            seq[0] = 8'($urandom_range(8'h7F));
        end else if (roll < 45 || pick == 1) begin
            seq[0] = 8'h C0 | 8'($urandom_range(8'h1F));
            seq[1] = 8'h80 | 8'($urandom_range(8'h3F));
            len = 2;
        end else if (roll < 65 || pick == 2) begin
            seq[0] = 8'hE0 | 8'($urandom_range(8'h0F));
            seq[1] = 8'h80 | 8'($urandom_range(8'h3F));
            seq[2] = 8'h80 | 8'($urandom_range(8'h3F));
            len = 3;
        end else if (roll < 82 || pick == 3) begin
            seq[0] = 8'hED;
            seq[1] = 8'hA0 | 8'($urandom_range(8'h0F));
            seq[2] = 8'h80 | 8'($urandom_range(8'h3F));
            seq[3] = 8'hED;
            seq[4] = 8'hB0 | 8'($urandom_range(8'h0F));
            seq[5] = 8'h80 | 8'($urandom_range(8'h3F));
            len = 6;
        end else begin
            seq[0] = 8'($urandom_range(8'hFF));
        end
        // Broken sequences are either cut short or get one byte replaced.
        if (pick != 0) begin
            if ($urandom_range(1) == 1) len = $urandom_range(1, len - 1);
            else seq[$urandom_range(1, len - 1)] = 8'($urandom_range(8'hFF));
        end
        for (int unsigned i = 0; i < len; i++) begin
            send_byte(seq[i], end_str && (i == len - 1));
        end
    endtask

    // Random strings under one idle pattern.
    task automatic run_random_strings(input int unsigned tx_pct, input int unsigned rx_pct,
                                      input int unsigned n_bytes);
        int unsigned target;
        target       = bytes_sent + n_bytes;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        while (bytes_sent < target) send_random_char($urandom_range(7) == 0);
    endtask

    // Hold the output for a long stretch while bytes keep coming.
    task automatic run_output_hold();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_req_len = 200;
        hold_req_id++;
        for (int unsigned i = 0; i < 16; i++) send_random_char(1'b0);
        send_byte(8'h2E, 1'b1);
    endtask

    initial begin : stimulus
        i_rst_n             <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.in_byte       <= 8'h00;
        in_ch.end_of_string <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed_strings();
        run_random_strings(0, 0, 62);
        run_random_strings(84, 0, 62);
        run_random_strings(0, 84, 62);
        run_random_strings(21, 21, 62);
        run_output_hold();

        // Flush whatever string is still open, then drain.
        send_byte(8'h0A, 1'b1);
        in_ch.valid <= 1'b0;
        while (chars_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Sent %0d bytes in %0d strings; checked %0d characters,",
                 bytes_sent, strings_sent, chars_checked);
        $display("%0d of them malformed and %0d supplementary; %0d faults.",
                 bad_seen, supp_seen, fault_cnt);
        if (fault_cnt == 0) begin
            $display("modified_utf8_decoder_top: match");
        end else begin
            $display("modified_utf8_decoder_top: mismatch");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin : watchdog
        #5_000_000;
        $display("Timeout with %0d characters still due.", chars_due.size());
        $display("modified_utf8_decoder_top: mismatch");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/mu8d_pkg.sv
hdl/mu8d_if.sv
hdl/mu8d_front.sv
hdl/mu8d_back.sv
hdl/modified_utf8_decoder_top.sv
hdl/mu8d_checker.sv
sim/modified_utf8_decoder_top_tb.sv
